// ----- hdl/wdts_pkg.sv -----
package wdts_pkg;

  // Field widths of the sample and level transactions.
  localparam int SAMPLE_W = 16;
  localparam int ALPHA_W  = 12;
  localparam int LEVEL_W  = 21;
  localparam int PROD_W   = ALPHA_W + SAMPLE_W;

  // Configuration register indexes and reset values.
  localparam logic REG_WARNING_ALPHA = 1'b0;
  localparam logic REG_ALARM_ALPHA   = 1'b1;
  localparam logic [ALPHA_W-1:0] WARNING_ALPHA_RESET = 12'd512;
  localparam logic [ALPHA_W-1:0] ALARM_ALPHA_RESET   = 12'd768;

  // Payload of one input transaction.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                eligible;
    logic                restart;
  } sample_item_t;

  // Payload of one output transaction.
  typedef struct packed {
    logic [LEVEL_W-1:0] warning_level;
    logic [LEVEL_W-1:0] alarm_level;
    logic               levels_valid;
  } level_item_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_SUM_DRAIN,
    ST_MEAN_LOAD,
    ST_DEV_START,
    ST_DEV,
    ST_DEV_DRAIN,
    ST_DEV_LOAD,
    ST_MIN,
    ST_MUL_WARN,
    ST_LEVEL_WARN,
    ST_LEVEL_ALARM,
    ST_STORE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_step;
    logic dev_mode;
    logic div_start;
    logic mean_capture;
    logic min_update;
    logic mul_en;
    logic mul_alarm;
    logic warn_write;
    logic alarm_write;
    logic store;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eval_go;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/wdts_stream_if.sv -----
interface wdts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/wdts_ctrl.sv -----
module wdts_ctrl import wdts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.scan_start = 1'b1;
        state_next     = status.eval_go ? ST_SUM : ST_STORE;
      end
      ST_SUM: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_SUM_DRAIN;
        end
      end
      ST_SUM_DRAIN: begin
        state_next = ST_MEAN_LOAD;
      end
      ST_MEAN_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DEV_START;
      end
      ST_DEV_START: begin
        cmd.mean_capture = 1'b1;
        cmd.scan_start   = 1'b1;
        state_next       = ST_DEV;
      end
      ST_DEV: begin
        cmd.scan_step = 1'b1;
        cmd.dev_mode  = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DEV_DRAIN;
        end
      end
      ST_DEV_DRAIN: begin
        cmd.dev_mode = 1'b1;
        state_next   = ST_DEV_LOAD;
      end
      ST_DEV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_MIN;
      end
      ST_MIN: begin
        cmd.min_update = 1'b1;
        state_next     = ST_MUL_WARN;
      end
      ST_MUL_WARN: begin
        cmd.mul_en = 1'b1;
        state_next = ST_LEVEL_WARN;
      end
      ST_LEVEL_WARN: begin
        cmd.warn_write = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_alarm  = 1'b1;
        state_next     = ST_LEVEL_ALARM;
      end
      ST_LEVEL_ALARM: begin
        cmd.alarm_write = 1'b1;
        state_next      = ST_STORE;
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/wdts_dp.sv -----
module wdts_dp import wdts_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  sample_item_t       item_in,
  input  logic [ALPHA_W-1:0] warning_alpha,
  input  logic [ALPHA_W-1:0] alarm_alpha,
  input  cmd_t               cmd,
  output status_t            status,
  wdts_stream_if.source      levels
);

  localparam int ADDR_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  // Division by WINDOW as a multiplication by the rounded-up reciprocal.
  // With the shift at SUM_W + clog2(WINDOW) the floor is exact for every sum.
  localparam int DIV_SH = SUM_W + ADDR_W;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'(((64'd1 << DIV_SH) + 64'(WINDOW - 1)) / 64'(WINDOW));

  // Latched transaction and window bookkeeping.
  sample_item_t        item;
  logic [FILL_W-1:0]   fill_count;
  logic [ADDR_W-1:0]   wr_pos;
  logic                pending_restart;

  // Window scan.
  logic [SAMPLE_W-1:0] history [WINDOW];
  logic [ADDR_W-1:0]   scan_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_valid;
  logic [SUM_W-1:0]    acc;
  logic [SAMPLE_W-1:0] abs_diff;

  // Divider by the window length.
  logic [2*SUM_W:0]    div_prod;
  logic [SAMPLE_W-1:0] quotient;

  // Minima, levels and output register.
  logic [SAMPLE_W-1:0] mean_q;
  logic [SAMPLE_W-1:0] least_mean;
  logic [SAMPLE_W-1:0] least_deviation;
  logic [PROD_W-1:0]   product;
  logic [LEVEL_W-1:0]  level_sum;
  logic [LEVEL_W-1:0]  warning_hold;
  logic [LEVEL_W-1:0]  alarm_hold;
  logic                valid_hold;
  logic                out_valid;
  level_item_t         out_item;

  // Status toward the controller.
  assign status.eval_go   = item.eligible && (fill_count == FILL_W'(WINDOW));
  assign status.scan_last = (scan_addr == ADDR_W'(WINDOW - 1));
  assign status.out_free  = !out_valid || levels.ready;

  // Item latch, restart flag and window fill state.
  always_ff @(posedge clk) begin
    if (rst) begin
      item            <= '0;
      fill_count      <= '0;
      wr_pos          <= '0;
      pending_restart <= 1'b1;
    end else begin
      if (cmd.load_item) begin
        item <= item_in;
        if (item_in.restart) begin
          pending_restart <= 1'b1;
        end
      end else if (cmd.min_update) begin
        pending_restart <= 1'b0;
      end
      if (cmd.store) begin
        wr_pos <= (wr_pos == ADDR_W'(WINDOW - 1)) ? '0 : wr_pos + ADDR_W'(1);
        if (fill_count != FILL_W'(WINDOW)) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end
    end
  end

  // History memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      history[wr_pos] <= item.sample;
    end
    if (cmd.scan_step) begin
      rd_data <= history[scan_addr];
    end
  end

  // Absolute distance of a stored sample from the mean.
  assign abs_diff = (mean_q >= rd_data) ? (mean_q - rd_data) : (rd_data - mean_q);

  // Scan address, read valid and the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      acc       <= '0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.scan_start) begin
        scan_addr <= '0;
        acc       <= '0;
      end else begin
        if (cmd.scan_step) begin
          scan_addr <= scan_addr + ADDR_W'(1);
        end
        if (rd_valid) begin
          acc <= acc + SUM_W'(cmd.dev_mode ? abs_diff : rd_data);
        end
      end
    end
  end

  // Quotient of the accumulated sum by the window length, registered.
  assign div_prod = {{(SUM_W + 1){1'b0}}, acc} * {{SUM_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quotient <= div_prod[DIV_SH +: SAMPLE_W];
    end
    if (cmd.mean_capture) begin
      mean_q <= quotient;
    end
  end

  // Running minima; a pending restart replaces them.
  always_ff @(posedge clk) begin
    if (rst) begin
      least_mean      <= '0;
      least_deviation <= '0;
    end else if (cmd.min_update) begin
      if (pending_restart || (mean_q < least_mean)) begin
        least_mean <= mean_q;
      end
      if (pending_restart || (quotient < least_deviation)) begin
        least_deviation <= quotient;
      end
    end
  end

  // Shared multiplier, registered before the level add.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product <= PROD_W'(cmd.mul_alarm ? alarm_alpha : warning_alpha) *
                 PROD_W'(least_deviation);
    end
  end

  assign level_sum = LEVEL_W'(least_mean) + LEVEL_W'(product[PROD_W-1:8]);

  // Held thresholds.
  always_ff @(posedge clk) begin
    if (rst) begin
      warning_hold <= '0;
      alarm_hold   <= '0;
      valid_hold   <= 1'b0;
    end else begin
      if (cmd.warn_write) begin
        warning_hold <= level_sum;
      end
      if (cmd.alarm_write) begin
        alarm_hold <= level_sum;
        valid_hold <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (levels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.warning_level <= warning_hold;
      out_item.alarm_level   <= alarm_hold;
      out_item.levels_valid  <= valid_hold;
    end
  end

  assign levels.valid = out_valid;
  assign levels.data  = out_item;

endmodule

// ----- hdl/window_deviation_threshold_setter_top.sv -----
// Channel   Role    Payload                                     Handshake
// samples   sink    sample[15:0], eligible, restart             valid/ready
// levels    source  warning_level[20:0], alarm_level[20:0],     valid/ready
//                   levels_valid
// config    write   wr_en, wr_index, wr_data[11:0]              write on wr_en
//
// One transaction is worked at a time. Without an evaluation a transaction only
// passes the check, store and finish states; with one its length is set by two
// scans of the history memory through its single read port.
// Each division by WINDOW is a reciprocal multiplication with a registered quotient.
// Reset is synchronous; no memory clearing pass is needed after it.
// A finished result waits in the output register while the next sample is taken;
// that sample's result then stalls until the output register is free.
module window_deviation_threshold_setter_top import wdts_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [ALPHA_W-1:0] wr_data,
  wdts_stream_if.sink        samples,
  wdts_stream_if.source      levels
);

  logic [ALPHA_W-1:0] warning_alpha;
  logic [ALPHA_W-1:0] alarm_alpha;
  logic               in_ready;
  cmd_t               cmd;
  status_t            status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      warning_alpha <= WARNING_ALPHA_RESET;
      alarm_alpha   <= ALARM_ALPHA_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_WARNING_ALPHA: warning_alpha <= wr_data;
        REG_ALARM_ALPHA:   alarm_alpha   <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign samples.ready = in_ready;

  wdts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wdts_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .item_in       (samples.data),
    .warning_alpha (warning_alpha),
    .alarm_alpha   (alarm_alpha),
    .cmd           (cmd),
    .status        (status),
    .levels        (levels)
  );

endmodule

// ----- verif/window_deviation_threshold_setter_top_tb.sv -----
module window_deviation_threshold_setter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wdts_pkg::*;

  localparam int WINDOW = 16;
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  // Cycles the block needs for one full evaluation, from the controller's state sequence.
  localparam int EVAL_CYCLES = 2 * WINDOW + 13;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 120;
  localparam int DIRECTED_ROWS = 24;

  typedef struct {
    sample_item_t item;
    bit           typed;
    level_item_t  want;
  } directed_row_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic wr_index;
  logic [ALPHA_W-1:0] wr_data;

  wdts_stream_if #(.payload_t(sample_item_t)) sample_ch ();
  wdts_stream_if #(.payload_t(level_item_t)) level_ch ();

  window_deviation_threshold_setter_top #(.WINDOW(WINDOW)) dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .samples  (sample_ch),
    .levels   (level_ch)
  );

  // Shadow copy of the block state used to work out the expected levels.
  logic [ALPHA_W-1:0]  mult_warning = WARNING_ALPHA_RESET;
  logic [ALPHA_W-1:0]  mult_alarm = ALARM_ALPHA_RESET;
  logic [SAMPLE_W-1:0] past_samples [WINDOW];
  int                  next_slot = 0;
  int                  stored = 0;
  logic [SAMPLE_W-1:0] least_mean = '0;
  logic [SAMPLE_W-1:0] least_dev = '0;
  logic                restart_due = 1'b1;
  logic [LEVEL_W-1:0]  warning_now = '0;
  logic [LEVEL_W-1:0]  alarm_now = '0;
  logic                levels_seen = 1'b0;

  level_item_t   expected_levels [$];
  directed_row_t directed_rows [DIRECTED_ROWS];
  int            errors = 0;
  int            quiet_cycles = 0;
  bit            send_stalls_on = 1'b1;
  bit            take_stalls_on = 1'b1;
  int            base_level = 0;
  int            jitter = 0;
  bit            alt_flip = 1'b0;
  level_item_t   got_levels;
  level_item_t   want_levels;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Threshold for one multiplier from the current minima.
  function automatic logic [LEVEL_W-1:0] level_from(input logic [ALPHA_W-1:0] alpha);
    logic [31:0] wide;
    wide = 32'(alpha);
    wide = wide * 32'(least_dev);
    wide = (wide >> 8) + 32'(least_mean);
    return wide[LEVEL_W-1:0];
  endfunction

  // Advance the shadow state by one sample and return the levels it yields.
  function automatic level_item_t predict_levels(input sample_item_t it);
    logic [SUM_W-1:0]    total;
    logic [SUM_W-1:0]    spread_sum;
    logic [SAMPLE_W-1:0] mean_now;
    logic [SAMPLE_W-1:0] dev_now;
    level_item_t         res;
    if (it.restart) begin
      restart_due = 1'b1;
    end
    // The evaluation covers the previous window only, not the new sample.
    if (it.eligible && stored == WINDOW) begin
      total = '0;
      for (int i = 0; i < WINDOW; i++) total += SUM_W'(past_samples[i]);
      total = total / SUM_W'(WINDOW);
      mean_now = total[SAMPLE_W-1:0];
      spread_sum = '0;
      for (int i = 0; i < WINDOW; i++) begin
        spread_sum += SUM_W'((mean_now >= past_samples[i]) ? mean_now - past_samples[i]
                                                           : past_samples[i] - mean_now);
      end
      spread_sum = spread_sum / SUM_W'(WINDOW);
      dev_now = spread_sum[SAMPLE_W-1:0];
      if (restart_due) begin
        least_mean = mean_now;
        least_dev = dev_now;
        restart_due = 1'b0;
      end else begin
        if (mean_now < least_mean) least_mean = mean_now;
        if (dev_now < least_dev) least_dev = dev_now;
      end
      warning_now = level_from(mult_warning);
      alarm_now = level_from(mult_alarm);
      levels_seen = 1'b1;
    end
    past_samples[next_slot] = it.sample;
    next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
    if (stored < WINDOW) stored++;
    res.warning_level = warning_now;
    res.alarm_level = alarm_now;
    res.levels_valid = levels_seen;
    return res;
  endfunction

  function automatic directed_row_t make_row(input logic [SAMPLE_W-1:0] s, input logic e,
                                             input logic r, input bit typed,
                                             input logic [LEVEL_W-1:0] lvl, input logic v);
    directed_row_t row;
    row.item.sample = s;
    row.item.eligible = e;
    row.item.restart = r;
    row.typed = typed;
    row.want.warning_level = lvl;
    row.want.alarm_level = lvl;
    row.want.levels_valid = v;
    return row;
  endfunction

  function automatic int draw_wait(input bit stalls_on);
    if (!stalls_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Random samples: extremes, full-range values, alternating extremes and values
  // clustered around a per-phase base so that the minima keep moving.
  function automatic sample_item_t random_sample_item();
    sample_item_t it;
    int           value;
    case ($urandom_range(0, 9))
      0: value = 0;
      1: value = 65535;
      2, 3: value = int'($urandom_range(0, 65535));
      4: begin
        alt_flip = ~alt_flip;
        value = alt_flip ? 65535 : 0;
      end
      default: begin
        value = base_level - jitter + int'($urandom_range(0, 2 * jitter));
        if (value < 0) value = 0;
        if (value > 65535) value = 65535;
      end
    endcase
    it.sample = value[SAMPLE_W-1:0];
    it.eligible = ($urandom_range(0, 3) != 0);
    it.restart = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // Present one sample, wait for its transaction and record the expected levels.
  task automatic push_sample(input sample_item_t it, input bit typed,
                             input level_item_t typed_levels);
    int          gap;
    level_item_t predicted;
    gap = draw_wait(send_stalls_on);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data <= it;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = predict_levels(it);
    expected_levels.push_back(typed ? typed_levels : predicted);
  endtask

  task automatic drain_levels();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic set_alphas(input logic [ALPHA_W-1:0] warn_mult,
                            input logic [ALPHA_W-1:0] alarm_mult);
    wr_en <= 1'b1;
    wr_index <= REG_WARNING_ALPHA;
    wr_data <= warn_mult;
    @(posedge clk);
    wr_index <= REG_ALARM_ALPHA;
    wr_data <= alarm_mult;
    @(posedge clk);
    wr_en <= 1'b0;
    mult_warning = warn_mult;
    mult_alarm = alarm_mult;
    @(posedge clk);
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Result receiver: random stalls on the ready side.
  initial begin
    int stall;
    forever begin
      stall = draw_wait(take_stalls_on);
      if (stall > 0) begin
        level_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      level_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(level_ch.valid && !rst)) @(posedge clk);
    end
  end

  // Check every level transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && level_ch.valid && level_ch.ready) begin
      got_levels = level_ch.data;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected levels transaction, expected none, actual %p",
                 $time, got_levels);
        errors++;
      end else begin
        want_levels = expected_levels.pop_front();
        compare_field("warning_level", want_levels.warning_level, got_levels.warning_level);
        compare_field("alarm_level", want_levels.alarm_level, got_levels.alarm_level);
        compare_field("levels_valid", want_levels.levels_valid, got_levels.levels_valid);
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (level_ch.valid && level_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sample_item_t       it;
    logic [ALPHA_W-1:0] next_warning;
    logic [ALPHA_W-1:0] next_alarm;
    level_item_t        no_levels;

    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_WARNING_ALPHA;
    wr_data <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.data <= '0;
    no_levels = '0;
    for (int i = 0; i < WINDOW; i++) past_samples[i] = '0;

    // Filling the window: eligible is ignored and a restart stays pending.
    for (int i = 0; i < 16; i++) begin
      directed_rows[i] = make_row(16'hFFFF, i[0], (i == 3), 1'b1, '0, 1'b0);
    end
    // First evaluation over a window of full-scale samples: zero deviation.
    directed_rows[16] = make_row(16'h0000, 1'b1, 1'b0, 1'b1, 21'd65535, 1'b1);
    // Not eligible, with a restart: levels are held.
    directed_rows[17] = make_row(16'h0000, 1'b0, 1'b1, 1'b1, 21'd65535, 1'b1);
    directed_rows[18] = make_row(16'h1234, 1'b1, 1'b0, 1'b0, '0, 1'b0);
    directed_rows[19] = make_row(16'hFFFF, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    directed_rows[20] = make_row(16'h8000, 1'b1, 1'b0, 1'b0, '0, 1'b0);
    directed_rows[21] = make_row(16'h0001, 1'b1, 1'b0, 1'b0, '0, 1'b0);
    directed_rows[22] = make_row(16'h7FFF, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    directed_rows[23] = make_row(16'h0000, 1'b0, 1'b0, 1'b0, '0, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the reset multipliers.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      push_sample(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each with its own multipliers and sample profile.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_levels();
      case (phase)
        0: begin
          next_warning = '0;
          next_alarm = '1;
        end
        1: begin
          next_warning = '1;
          next_alarm = '0;
        end
        2: begin
          next_warning = '1;
          next_alarm = '1;
        end
        3: begin
          next_warning = '0;
          next_alarm = '0;
        end
        default: begin
          next_warning = ALPHA_W'($urandom_range(0, 4095));
          next_alarm = ALPHA_W'($urandom_range(0, 4095));
        end
      endcase
      set_alphas(next_warning, next_alarm);
      send_stalls_on = (phase != 3);
      take_stalls_on = (phase != 3);
      base_level = $urandom_range(0, 65535);
      jitter = (1 << (4 * $urandom_range(0, 3))) - 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off the sender once until every level has come back.
        if (phase == 2 && n == PHASE_ITEMS / 2) drain_levels();
        it = random_sample_item();
        // New multipliers must not touch the held levels.
        if (n == 0) it.eligible = 1'b0;
        push_sample(it, 1'b0, no_levels);
      end
    end

    drain_levels();
    repeat (EVAL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_levels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
